FILE: src/dbvl_pkg.sv
package dbvl_pkg;

	localparam int WORD_BITS_DEF  = 64;
	localparam int MAX_BLOCKS_DEF = 64;
	localparam int POS_W          = 13;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

endpackage

FILE: src/dynamic_bit_vector_leaf.sv
// channel  | signals                              | handshake
// ---------+--------------------------------------+------------------------------
// command  | opcode, position, new_bit            | taken when start & !busy
// result   | stored_bit, ones_before, status      | valid for the one cycle of done
//
// An item first scans the fill counts of all used blocks in the block memory
// (one read port, one write port); if the position lies in a stored word, a masked
// popcount counts its ones a byte at a time; an insert adds a decision state and
// one or two writes; a split adds a popcount and a read and write per block moved.
// Reset clears the block count, not the memory; entries past the count go unused.
// busy stays high from acceptance through the done cycle; results cannot be stalled.
module dynamic_bit_vector_leaf
	import dbvl_pkg::*;
#(
	parameter int WORD_BITS  = WORD_BITS_DEF,
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             opcode,
	input  logic [POS_W-1:0] position,
	input  logic             new_bit,
	output logic             done,
	output logic             stored_bit,
	output logic [POS_W-1:0] ones_before,
	output logic [1:0]       status
);

	localparam int W  = WORD_BITS;
	localparam int M  = MAX_BLOCKS;
	localparam int H  = W / 2;
	localparam int FW = $clog2(W + 1);
	localparam int AW = $clog2(M);
	localparam int UW = $clog2(M + 1);
	localparam int TW = $clog2(M * W + 1);
	localparam int CW = (TW > POS_W) ? TW : POS_W + 1;
	localparam int EW = W + 2 * FW;

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_RD   = 11'b00000000010,
		S_ACC  = 11'b00000000100,
		S_EVAL = 11'b00000001000,
		S_POP  = 11'b00000010000,
		S_DEC  = 11'b00000100000,
		S_SPL  = 11'b00001000000,
		S_SHR  = 11'b00010000000,
		S_SHW  = 11'b00100000000,
		S_W1   = 11'b01000000000,
		S_W2   = 11'b10000000000
	} state_t;

	// S_OUT folded into the out_q flag, raised as the state returns to S_IDLE
	state_t         state_q;
	logic           out_q;
	logic [UW-1:0]  used_q, idx_q;
	logic           inc_q, two_q, hit_q;
	logic           op_q, nbit_q;
	logic [POS_W-1:0] pos_q;
	logic [CW-1:0]  acc_q, oacc_q, opre_q;
	logic [AW-1:0]  b_q, wa1_q, wa2_q;
	logic [EW-1:0]  wd1_q, wd2_q;
	logic [W-1:0]   lw_q, pw_q, wb_q, nw_q;
	logic [FW-1:0]  lf_q, lo_q, pf_q, po_q, fb_q, ob_q, nf_q, no_q, off_q;
	logic           sbit_q;
	logic [POS_W-1:0] rank_q;
	logic [1:0]     status_q;
	logic           pop_go_q;
	logic [FW-1:0]  pop_n_q;

	logic           we;
	logic [AW-1:0]  waddr, raddr;
	logic [EW-1:0]  wdata, rdata;
	logic           pop_done;
	logic [FW-1:0]  pop_cnt;

	logic [W-1:0]   rw;
	logic [FW-1:0]  rf, ro;
	logic [CW-1:0]  posx, sum;
	logic [UW-1:0]  um1, im1, bp1u;
	logic           last_room, full_blk, b_room, next_ok, prev_ok, tb, fb0;
	logic [W-1:0]   lo_w, hi_w, half_mask;
	logic [FW-1:0]  lo_o, hi_o, wfull;

	function automatic logic [W-1:0] put_bit(input logic [W-1:0] w, input logic [FW-1:0] o,
			input logic b);
		logic [W-1:0] r;
		for (int k = 0; k < W; k++) begin
			if (k < int'(o)) r[k] = w[k];
			else if (k == int'(o)) r[k] = b;
			else r[k] = w[(k == 0) ? 0 : k - 1];
		end
		return r;
	endfunction

	dbvl_ram #(.WIDTH(EW), .DEPTH(M)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	dbvl_popcnt #(.W(W)) u_pop (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (pop_go_q),
		.word   (wb_q),
		.n      (pop_n_q),
		.done   (pop_done),
		.cnt    (pop_cnt)
	);

	assign rw        = rdata[EW-1 -: W];
	assign rf        = rdata[2*FW-1:FW];
	assign ro        = rdata[FW-1:0];
	assign posx      = CW'(pos_q);
	assign sum       = acc_q + CW'(rf);
	assign um1       = used_q - UW'(1);
	assign im1       = idx_q - UW'(1);
	assign bp1u      = UW'(b_q) + UW'(1);
	assign wfull     = FW'(W);
	assign last_room = lf_q < wfull;
	assign full_blk  = used_q == UW'(M);
	assign b_room    = fb_q < wfull;
	assign next_ok   = (bp1u < used_q) && (nf_q < wfull);
	assign prev_ok   = (b_q != '0) && (pf_q < wfull);
	assign tb        = wb_q[W-1];
	assign fb0       = wb_q[0];
	assign half_mask = {{(W-H){1'b0}}, {H{1'b1}}};
	assign lo_w      = wb_q & half_mask;
	assign hi_w      = wb_q >> H;
	assign lo_o      = pop_cnt;
	assign hi_o      = ob_q - pop_cnt;

	assign raddr = (state_q == S_SHR) ? im1[AW-1:0] : idx_q[AW-1:0];
	assign we    = (state_q == S_SHW) || (state_q == S_W1) || (state_q == S_W2);

	always_comb begin
		case (state_q)
			S_SHW: begin
				waddr = idx_q[AW-1:0];
				wdata = rdata;
			end
			S_W2: begin
				waddr = wa2_q;
				wdata = wd2_q;
			end
			default: begin
				waddr = wa1_q;
				wdata = wd1_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			out_q    <= 1'b0;
			used_q   <= '0;
			inc_q    <= 1'b0;
			two_q    <= 1'b0;
			hit_q    <= 1'b0;
			pop_go_q <= 1'b0;
		end else begin
			out_q    <= 1'b0;
			pop_go_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (out_q) begin
						out_q <= 1'b0;
					end else if (start) begin
						op_q     <= opcode;
						pos_q    <= position;
						nbit_q   <= new_bit;
						idx_q    <= '0;
						acc_q    <= '0;
						oacc_q   <= '0;
						hit_q    <= 1'b0;
						inc_q    <= 1'b0;
						two_q    <= 1'b0;
						sbit_q   <= 1'b0;
						rank_q   <= '0;
						status_q <= ST_OK;
						lw_q     <= '0;
						lf_q     <= '0;
						lo_q     <= '0;
						state_q  <= S_RD;
					end
				end
				S_RD: begin
					state_q <= (idx_q == used_q) ? S_EVAL : S_ACC;
				end
				S_ACC: begin
					if (!hit_q && (posx < sum)) begin
						hit_q  <= 1'b1;
						b_q    <= idx_q[AW-1:0];
						off_q  <= FW'(posx - acc_q);
						opre_q <= oacc_q;
						wb_q   <= rw;
						fb_q   <= rf;
						ob_q   <= ro;
						pw_q   <= lw_q;
						pf_q   <= lf_q;
						po_q   <= lo_q;
					end else if (!hit_q) begin
						oacc_q <= oacc_q + CW'(ro);
					end
					if (hit_q && (idx_q == bp1u)) begin
						nw_q <= rw;
						nf_q <= rf;
						no_q <= ro;
					end
					lw_q    <= rw;
					lf_q    <= rf;
					lo_q    <= ro;
					acc_q   <= sum;
					idx_q   <= idx_q + UW'(1);
					state_q <= S_RD;
				end
				S_EVAL: begin
					if ((op_q == OP_QUERY) ? (posx >= acc_q) : (posx > acc_q)) begin
						status_q <= ST_RANGE;
						out_q    <= 1'b1;
						state_q  <= S_IDLE;
					end else if (hit_q) begin
						pop_go_q <= 1'b1;
						pop_n_q  <= off_q;
						state_q  <= S_POP;
					end else begin
						rank_q  <= oacc_q[POS_W-1:0];
						state_q <= S_DEC;
					end
				end
				S_POP: begin
					if (pop_done) begin
						rank_q <= POS_W'(opre_q + CW'(pop_cnt));
						if (op_q == OP_QUERY) begin
							sbit_q  <= wb_q[off_q[$clog2(W)-1:0]];
							out_q   <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_DEC;
						end
					end
				end
				S_DEC: begin
					state_q <= S_W1;
					if (!hit_q) begin
						if (used_q != '0 && last_room) begin
							wa1_q <= um1[AW-1:0];
							wd1_q <= {put_bit(lw_q, lf_q, nbit_q), lf_q + FW'(1),
								lo_q + FW'(nbit_q)};
						end else if (full_blk) begin
							status_q <= ST_FULL;
							out_q    <= 1'b1;
							state_q  <= S_IDLE;
						end else begin
							wa1_q <= used_q[AW-1:0];
							wd1_q <= {W'(nbit_q), FW'(1), FW'(nbit_q)};
							inc_q <= 1'b1;
						end
					end else if (b_room) begin
						wa1_q <= b_q;
						wd1_q <= {put_bit(wb_q, off_q, nbit_q), fb_q + FW'(1),
							ob_q + FW'(nbit_q)};
					end else if (next_ok) begin
						// spill the top bit into the next word
						wa1_q <= b_q;
						wd1_q <= {put_bit(wb_q, off_q, nbit_q), fb_q,
							ob_q + FW'(nbit_q) - FW'(tb)};
						wa2_q <= b_q + AW'(1);
						wd2_q <= {put_bit(nw_q, '0, tb), nf_q + FW'(1), no_q + FW'(tb)};
						two_q <= 1'b1;
					end else if (prev_ok) begin
						wa1_q <= b_q - AW'(1);
						if (off_q == '0) begin
							wd1_q <= {put_bit(pw_q, pf_q, nbit_q), pf_q + FW'(1),
								po_q + FW'(nbit_q)};
						end else begin
							// spill the bottom bit into the previous word
							wd1_q <= {put_bit(pw_q, pf_q, fb0), pf_q + FW'(1),
								po_q + FW'(fb0)};
							wa2_q <= b_q;
							wd2_q <= {put_bit(wb_q >> 1, off_q - FW'(1), nbit_q), fb_q,
								ob_q + FW'(nbit_q) - FW'(fb0)};
							two_q <= 1'b1;
						end
					end else if (full_blk) begin
						status_q <= ST_FULL;
						out_q    <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						pop_go_q <= 1'b1;
						pop_n_q  <= FW'(H);
						idx_q    <= used_q;
						inc_q    <= 1'b1;
						state_q  <= S_SPL;
					end
				end
				S_SPL: begin
					if (pop_done) begin
						wa1_q <= b_q;
						wa2_q <= b_q + AW'(1);
						two_q <= 1'b1;
						if (off_q < FW'(H)) begin
							wd1_q <= {put_bit(lo_w, off_q, nbit_q), FW'(H + 1),
								lo_o + FW'(nbit_q)};
							wd2_q <= {hi_w, FW'(W - H), hi_o};
						end else begin
							wd1_q <= {lo_w, FW'(H), lo_o};
							wd2_q <= {put_bit(hi_w, off_q - FW'(H), nbit_q), FW'(W - H + 1),
								hi_o + FW'(nbit_q)};
						end
						state_q <= (idx_q > bp1u) ? S_SHR : S_W1;
					end
				end
				S_SHR: begin
					state_q <= S_SHW;
				end
				S_SHW: begin
					// move entry idx-1 up to idx, walking down toward the split
					idx_q   <= im1;
					state_q <= (im1 > bp1u) ? S_SHR : S_W1;
				end
				S_W1: begin
					if (two_q) begin
						state_q <= S_W2;
					end else begin
						used_q  <= used_q + UW'(inc_q);
						out_q   <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_W2: begin
					used_q  <= used_q + UW'(inc_q);
					out_q   <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE) || out_q;
	assign done        = out_q;
	assign stored_bit  = sbit_q;
	assign ones_before = rank_q;
	assign status      = status_q;

endmodule

FILE: src/dbvl_ram.sv
module dbvl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/dbvl_popcnt.sv
module dbvl_popcnt #(
	parameter int W = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  logic [W-1:0]             word,
	input  logic [$clog2(W+1)-1:0]   n,
	output logic                     done,
	output logic [$clog2(W+1)-1:0]   cnt
);

	localparam int FW  = $clog2(W + 1);
	localparam int NCH = (W + 7) / 8;
	localparam int PW  = NCH * 8;
	localparam int LW  = $clog2(NCH + 1);

	logic [PW-1:0] sh_q;
	logic [FW-1:0] cnt_q;
	logic [LW-1:0] left_q;
	logic          run_q;
	logic          done_q;
	logic [W-1:0]  masked;
	logic [3:0]    pc8;

	// keep only the low n bits
	always_comb begin
		for (int k = 0; k < W; k++) begin
			masked[k] = word[k] & (k < int'(n));
		end
	end

	always_comb begin
		pc8 = '0;
		for (int k = 0; k < 8; k++) begin
			pc8 = pc8 + 4'(sh_q[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			left_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				sh_q   <= PW'(masked);
				cnt_q  <= '0;
				left_q <= LW'(NCH);
				run_q  <= 1'b1;
			end else if (run_q) begin
				cnt_q  <= cnt_q + FW'(pc8);
				sh_q   <= sh_q >> 8;
				left_q <= left_q - LW'(1);
				if (left_q == LW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign cnt  = cnt_q;

endmodule

FILE: src/dbvl_check.sv
module dbvl_check
	import dbvl_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             opcode,
	input logic [POS_W-1:0] position,
	input logic             new_bit,
	input logic             done,
	input logic             stored_bit,
	input logic [POS_W-1:0] ones_before,
	input logic [1:0]       status
);

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after a command word");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result shown while idle");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_FULL || status == ST_RANGE))
		else $error("bad status code");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_RANGE) |-> (ones_before == '0 && !stored_bit))
		else $error("out of range result not zeroed");

endmodule

bind dynamic_bit_vector_leaf dbvl_check u_dbvl_check (.*);

FILE: sim/dynamic_bit_vector_leaf_chk.sv
`timescale 1ns / 100ps

module dynamic_bit_vector_leaf_chk
	import dbvl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  logic             opcode,
	input  logic [POS_W-1:0] position,
	input  logic             new_bit,
	input  logic             done,
	input  logic             stored_bit,
	input  logic [POS_W-1:0] ones_before,
	input  logic [1:0]       status,
	output int               mismatches,
	output int               pending
);

	localparam int WB = WORD_BITS_DEF;
	localparam int MB = MAX_BLOCKS_DEF;
	localparam int HB = WB / 2;

	typedef struct packed {
		logic             bit_val;
		logic [POS_W-1:0] rank;
		logic [1:0]       st;
	} leaf_result_t;

	logic [WB-1:0] leaf_word[MB];
	int unsigned   leaf_fill[MB];
	int unsigned   leaf_ones[MB];
	int unsigned   leaf_count;
	leaf_result_t  results_due[$];

	function automatic logic [WB-1:0] low_bits(int unsigned n);
		if (n >= WB)
			return '1;
		return (64'd1 << n) - 64'd1;
	endfunction

	function automatic logic [WB-1:0] shove_in(logic [WB-1:0] w, int unsigned o, logic b);
		logic [WB-1:0] m;
		m = low_bits(o);
		return (w & m) | ((w & ~m) << 1) | (WB'(b) << o);
	endfunction

	task automatic add_bit(int unsigned k, int unsigned o, logic b);
		leaf_word[k] = shove_in(leaf_word[k], o, b);
		leaf_fill[k] += 1;
		leaf_ones[k] += b;
	endtask

	task automatic locate(int unsigned p, output int unsigned blk, output int unsigned pre);
		int unsigned acc;
		int unsigned i;
		acc = 0;
		for (i = 0; i < leaf_count; i++) begin
			if (p < acc + leaf_fill[i])
				break;
			acc += leaf_fill[i];
		end
		pre = acc;
		blk = i;
	endtask

	function automatic int unsigned rank_of(int unsigned p);
		int unsigned acc;
		int unsigned r;
		acc = 0;
		r = 0;
		for (int unsigned i = 0; i < leaf_count; i++) begin
			if (p >= acc + leaf_fill[i]) begin
				acc += leaf_fill[i];
				r += leaf_ones[i];
			end else begin
				r += $countones(leaf_word[i] & low_bits(p - acc));
				break;
			end
		end
		return r;
	endfunction

	// returns 1 when the insert is refused for lack of a free block
	task automatic insert_bit(int unsigned p, logic nb, output logic refused);
		int unsigned pre, b, off;
		logic t;
		refused = 1'b0;
		locate(p, b, pre);
		if (b >= leaf_count) begin
			if (b > 0 && leaf_fill[b-1] < WB) begin
				b--;
				pre -= leaf_fill[b];
			end else begin
				if (leaf_count >= MB) begin
					refused = 1'b1;
					return;
				end
				b = leaf_count;
				leaf_word[b] = '0;
				leaf_fill[b] = 0;
				leaf_ones[b] = 0;
				leaf_count++;
			end
		end
		off = p - pre;
		if (leaf_fill[b] < WB) begin
			add_bit(b, off, nb);
		end else if (b + 1 < leaf_count && leaf_fill[b+1] < WB) begin
			// push the top bit into the next word
			t = leaf_word[b][WB-1];
			add_bit(b + 1, 0, t);
			leaf_word[b] = shove_in(leaf_word[b], off, nb);
			leaf_ones[b] = leaf_ones[b] + nb - t;
		end else if (b >= 1 && leaf_fill[b-1] < WB) begin
			if (off == 0) begin
				add_bit(b - 1, leaf_fill[b-1], nb);
			end else begin
				t = leaf_word[b][0];
				add_bit(b - 1, leaf_fill[b-1], t);
				leaf_word[b] = shove_in(leaf_word[b] >> 1, off - 1, nb);
				leaf_ones[b] = leaf_ones[b] + nb - t;
			end
		end else begin
			if (leaf_count >= MB) begin
				refused = 1'b1;
				return;
			end
			for (int unsigned i = leaf_count; i > b + 1; i--) begin
				leaf_word[i] = leaf_word[i-1];
				leaf_fill[i] = leaf_fill[i-1];
				leaf_ones[i] = leaf_ones[i-1];
			end
			leaf_word[b+1] = leaf_word[b] >> HB;
			leaf_word[b] &= low_bits(HB);
			leaf_fill[b] = HB;
			leaf_fill[b+1] = WB - HB;
			leaf_ones[b] = $countones(leaf_word[b]);
			leaf_ones[b+1] = $countones(leaf_word[b+1]);
			leaf_count++;
			if (off < HB)
				add_bit(b, off, nb);
			else
				add_bit(b + 1, off - HB, nb);
		end
	endtask

	task automatic predict_word(logic op, int unsigned p, logic nb);
		leaf_result_t e;
		int unsigned total, b, pre;
		logic refused;
		e = '0;
		total = 0;
		for (int unsigned i = 0; i < leaf_count; i++)
			total += leaf_fill[i];
		if (op == OP_QUERY) begin
			if (p >= total) begin
				e.st = ST_RANGE;
			end else begin
				locate(p, b, pre);
				e.bit_val = leaf_word[b][(p - pre) & 63];
				e.rank = POS_W'(rank_of(p));
			end
		end else begin
			if (p > total) begin
				e.st = ST_RANGE;
			end else begin
				e.rank = POS_W'(rank_of(p));
				insert_bit(p, nb, refused);
				if (refused)
					e.st = ST_FULL;
			end
		end
		results_due.push_back(e);
	endtask

	task automatic report(string what, int unsigned exp_v, int unsigned got_v);
		if (mismatches < 10)
			$display("%0t: %s expected %0d got %0d", $time, what, exp_v, got_v);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		leaf_result_t e;
		if (!arst_n) begin
			leaf_count = 0;
			for (int i = 0; i < MB; i++) begin
				leaf_word[i] = '0;
				leaf_fill[i] = 0;
				leaf_ones[i] = 0;
			end
			results_due.delete();
			mismatches = 0;
		end else begin
			if (done) begin
				if (results_due.size() == 0) begin
					report("unexpected result, count", 0, 1);
				end else begin
					e = results_due.pop_front();
					if (stored_bit !== e.bit_val)
						report("stored_bit", e.bit_val, stored_bit);
					if (ones_before !== e.rank)
						report("ones_before", e.rank, ones_before);
					if (status !== e.st)
						report("status", e.st, status);
				end
			end
			if (start && !busy)
				predict_word(opcode, position, new_bit);
		end
		pending = results_due.size();
	end

endmodule

FILE: sim/dynamic_bit_vector_leaf_tb.sv
`timescale 1ns / 100ps

module dynamic_bit_vector_leaf_tb;
	import dbvl_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic             opcode;
	logic [POS_W-1:0] position;
	logic             new_bit;
	logic             done;
	logic             stored_bit;
	logic [POS_W-1:0] ones_before;
	logic [1:0]       status;
	int               mismatches;
	int               pending;

	int unsigned seq_len;
	logic        ops_open[$];
	bit          gaps_on;

	dynamic_bit_vector_leaf u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .position(position), .new_bit(new_bit),
		.done(done), .stored_bit(stored_bit), .ones_before(ones_before),
		.status(status)
	);

	dynamic_bit_vector_leaf_chk u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .position(position), .new_bit(new_bit),
		.done(done), .stored_bit(stored_bit), .ones_before(ones_before),
		.status(status), .mismatches(mismatches), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// track sequence length from results to steer positions
	always @(posedge clk or negedge arst_n) begin
		logic op;
		if (!arst_n) begin
			seq_len <= 0;
		end else begin
			if (done && ops_open.size() > 0) begin
				op = ops_open.pop_front();
				if (op == OP_INSERT && status == ST_OK)
					seq_len <= seq_len + 1;
			end
			if (start && !busy)
				ops_open.push_back(opcode);
		end
	end

	// called at a falling edge; returns at a falling edge after acceptance
	task automatic send_word(logic op, int unsigned p, logic nb);
		opcode <= op;
		position <= POS_W'(p);
		new_bit <= nb;
		start <= 1'b1;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			opcode <= 1'($urandom_range(0, 1));
			position <= POS_W'($urandom);
			new_bit <= 1'($urandom_range(0, 1));
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	task automatic random_word(int unsigned ins_pct);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8)
			send_word(1'($urandom_range(0, 1)), $urandom_range(0, 8191),
				1'($urandom_range(0, 1)));
		else if (r < 8 + ins_pct || seq_len == 0)
			send_word(OP_INSERT, $urandom_range(0, seq_len), 1'($urandom_range(0, 1)));
		else
			send_word(OP_QUERY, $urandom_range(0, seq_len - 1), 1'b0);
	endtask

	initial begin
		int unsigned n;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_INSERT;
		position = '0;
		new_bit = 1'b0;
		gaps_on = 1'b1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty store, range edges, appends and extremes
		send_word(OP_QUERY, 0, 1'b0);
		send_word(OP_INSERT, 1, 1'b1);
		send_word(OP_INSERT, 8191, 1'b1);
		send_word(OP_QUERY, 8191, 1'b1);
		send_word(OP_INSERT, 0, 1'b1);
		send_word(OP_INSERT, 1, 1'b0);
		send_word(OP_INSERT, 2, 1'b1);
		send_word(OP_INSERT, 0, 1'b0);
		send_word(OP_QUERY, 0, 1'b1);
		send_word(OP_QUERY, 1, 1'b0);
		send_word(OP_QUERY, 3, 1'b0);
		send_word(OP_QUERY, 4, 1'b0);
		send_word(OP_INSERT, 5, 1'b1);
		send_word(OP_INSERT, 4096, 1'b0);
		for (int i = 0; i < 8; i++)
			send_word(OP_INSERT, 4 + i, i[0]);

		// hold until everything drains
		start <= 1'b0;
		while (pending != 0) @(negedge clk);

		// mostly inserts, to grow the store through spills, splits and moves
		for (n = 0; n < 1670; n++)
			random_word(75);

		gaps_on = 1'b0;
		for (n = 0; n < 60; n++)
			random_word(50);
		start <= 1'b0;

		n = 0;
		while (pending != 0 && n < 100000) begin
			@(negedge clk);
			n++;
		end
		if (pending != 0) begin
			$display("end of test: mismatches");
			$finish;
		end
		repeat (400) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: filelist.f
src/dbvl_pkg.sv
src/dbvl_ram.sv
src/dbvl_popcnt.sv
src/dynamic_bit_vector_leaf.sv
src/dbvl_check.sv
sim/dynamic_bit_vector_leaf_chk.sv
sim/dynamic_bit_vector_leaf_tb.sv
